/* rtl/lpg_pkg.sv */
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, register indexes and the sequencer control store for the
// landmark pair generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int BIN_W   = 12;
   localparam int FRAME_W = 16;
   localparam int FAN_W   = 4;
   localparam int IDX_W   = 2;
   localparam int STEP_W  = 2;

   // configuration register indexes
   localparam logic [IDX_W-1:0] CSR_PAIR_FAN  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_MIN_DELTA = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_DELTA = 2'd2;

   localparam logic [FAN_W-1:0]   FAN_RESET       = 4'd14;
   localparam logic [FRAME_W-1:0] MIN_DELTA_RESET = 16'd0;
   localparam logic [FRAME_W-1:0] MAX_DELTA_RESET = 16'd200;

   // program step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = 2'd0;
   localparam logic [STEP_W-1:0] STEP_SCAN   = 2'd1;
   localparam logic [STEP_W-1:0] STEP_FINISH = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_SCAN,
      ACT_FINISH
   } act_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NO_BEAT,
      COND_SCAN_BUSY,
      COND_OUT_BLOCKED
   } cond_type;

   typedef struct packed {
      act_type           act;
      cond_type          cond;
      logic [STEP_W-1:0] jump;
      logic [STEP_W-1:0] next;
   } ctrl_word_type;

   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic [FRAME_W-1:0] frame;
   } peak_type;

   // control store: jump while the condition holds, else go to next
   function automatic ctrl_word_type step_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:   w = '{ACT_ACCEPT, COND_NO_BEAT,     STEP_IDLE,   STEP_SCAN};
         STEP_SCAN:   w = '{ACT_SCAN,   COND_SCAN_BUSY,   STEP_SCAN,   STEP_FINISH};
         STEP_FINISH: w = '{ACT_FINISH, COND_OUT_BLOCKED, STEP_FINISH, STEP_IDLE};
         default:     w = '{ACT_NONE,   COND_NEVER,       STEP_IDLE,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/landmark_pair_generator.sv */
// ----------------------------------------------------------------------------
// landmark_pair_generator
// Pairs each incoming spectrogram peak with the recent peaks held in a ring,
// emitting one beat per pair whose frame difference lies in the set range.
// ----------------------------------------------------------------------------
// Each peak passes through an accept step, a scan step with one window memory
// read for each of the newest min(pair_fan, held peaks) held peaks, a last-read
// drain and a finish step that updates the ring. A stalled result side can
// hold the scan and finish steps. Each pair waits for the next hit or the finish.
// Reset empties the window and loads pair_fan 14, min 0, max 200.
module landmark_pair_generator #(
   parameter int WINDOW_DEPTH = 14
) (
   input  logic        clock,
   input  logic        reset,
   // peak_bin [11:0], peak_frame [27:12], zero [31:28]
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // anchor_bin [11:0], target_bin [23:12], frame_delta [39:24],
   // anchor_frame [55:40]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW = (CW > lpg_pkg::FAN_W) ? CW : lpg_pkg::FAN_W;
   localparam int SW = CW + 1;
   localparam int BW = lpg_pkg::BIN_W;
   localparam int TW = lpg_pkg::FRAME_W;

   lpg_pkg::ctrl_word_type ctrl;

   lpg_pkg::peak_type window_mem [WINDOW_DEPTH];

   logic [lpg_pkg::STEP_W-1:0] step_ff, step_in;
   logic [lpg_pkg::FAN_W-1:0]  fan_ff, fan_in;
   logic [TW-1:0]              min_ff, min_in, max_ff, max_in;
   logic [CW-1:0]              held_ff, held_in, remain_ff, remain_in;
   logic [AW-1:0]              wslot_ff, wslot_in, rslot_ff, rslot_in;
   logic [BW-1:0]              item_bin_ff, item_bin_in;
   logic [TW-1:0]              item_frame_ff, item_frame_in;
   logic                       item_last_ff, item_last_in;
   logic                       rd_valid_ff, rd_valid_in;
   lpg_pkg::peak_type          rd_ff;
   logic                       pend_valid_ff, pend_valid_in;
   logic [BW-1:0]              pend_bin_ff, pend_bin_in;
   logic [TW-1:0]              pend_delta_ff, pend_delta_in, pend_frame_ff, pend_frame_in;
   logic                       rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [55:0]                rsp_data_ff, rsp_data_in;

   logic          req_beat, out_busy, qualify, test_hit;
   logic          scan_stall, scan_go, finish_stall, finish_go, cond_true;
   logic          rd_issue, mem_write;
   logic [TW-1:0] delta;
   logic [FW-1:0] fan_eff;
   logic [CW-1:0] n_pairs;
   logic [SW-1:0] start_sum;
   logic [AW-1:0] rslot_next, wslot_next;

   always_comb begin
      ctrl         = lpg_pkg::step_rom(step_ff);
      req_tready   = (ctrl.act == lpg_pkg::ACT_ACCEPT);
      req_beat     = req_tvalid && req_tready;
      csr_ready    = 1'b1;
      out_busy     = rsp_valid_ff && !rsp_tready;

      delta        = item_frame_ff - rd_ff.frame;
      qualify      = (item_frame_ff >= rd_ff.frame) && (delta >= min_ff) && (delta <= max_ff);
      test_hit     = rd_valid_ff && qualify;
      scan_stall   = test_hit && pend_valid_ff && out_busy;
      scan_go      = (ctrl.act == lpg_pkg::ACT_SCAN) && !scan_stall;
      finish_stall = pend_valid_ff && out_busy;
      finish_go    = (ctrl.act == lpg_pkg::ACT_FINISH) && !finish_stall;
      rd_issue     = scan_go && (remain_ff != '0);
      mem_write    = finish_go && !item_last_ff;

      case (ctrl.cond)
         lpg_pkg::COND_NO_BEAT:     cond_true = !req_beat;
         lpg_pkg::COND_SCAN_BUSY:   cond_true = scan_stall || (remain_ff != '0);
         lpg_pkg::COND_OUT_BLOCKED: cond_true = finish_stall;
         default:                   cond_true = 1'b0;
      endcase
      step_in = cond_true ? ctrl.jump : ctrl.next;

      // effective fan and oldest slot of the scan
      fan_eff = (FW'(fan_ff) > FW'(WINDOW_DEPTH)) ? FW'(WINDOW_DEPTH) : FW'(fan_ff);
      n_pairs = (fan_eff < FW'(held_ff)) ? fan_eff[CW-1:0] : held_ff;
      start_sum = SW'(wslot_ff) + SW'(WINDOW_DEPTH) - SW'(n_pairs);
      if (start_sum >= SW'(WINDOW_DEPTH)) begin
         start_sum = start_sum - SW'(WINDOW_DEPTH);
      end
      rslot_next = (rslot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : rslot_ff + 1'b1;
      wslot_next = (wslot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_ff + 1'b1;

      // configuration
      fan_in = fan_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lpg_pkg::CSR_PAIR_FAN:  fan_in = csr_data[lpg_pkg::FAN_W-1:0];
            lpg_pkg::CSR_MIN_DELTA: min_in = csr_data;
            lpg_pkg::CSR_MAX_DELTA: max_in = csr_data;
            default: ;
         endcase
      end

      item_bin_in   = item_bin_ff;
      item_frame_in = item_frame_ff;
      item_last_in  = item_last_ff;
      remain_in     = remain_ff;
      rslot_in      = rslot_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_bin_in   = pend_bin_ff;
      pend_delta_in = pend_delta_ff;
      pend_frame_in = pend_frame_ff;
      held_in       = held_ff;
      wslot_in      = wslot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;

      if (req_beat) begin
         item_bin_in   = req_tdata[BW-1:0];
         item_frame_in = req_tdata[BW+TW-1:BW];
         item_last_in  = req_tlast;
         remain_in     = n_pairs;
         rslot_in      = start_sum[AW-1:0];
         rd_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (scan_go) begin
         rd_valid_in = rd_issue;
         if (rd_issue) begin
            rslot_in  = rslot_next;
            remain_in = remain_ff - 1'b1;
         end
         // a pair waits until the next hit or the end tells whether it is last
         if (test_hit) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {pend_frame_ff, pend_delta_ff, item_bin_ff, pend_bin_ff};
            end
            pend_valid_in = 1'b1;
            pend_bin_in   = rd_ff.bin;
            pend_delta_in = delta;
            pend_frame_in = rd_ff.frame;
         end
      end

      if (finish_go) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_data_in  = {pend_frame_ff, pend_delta_ff, item_bin_ff, pend_bin_ff};
         end
         pend_valid_in = 1'b0;
         if (item_last_ff) begin
            held_in  = '0;
            wslot_in = '0;
         end else begin
            wslot_in = wslot_next;
            if (held_ff < CW'(WINDOW_DEPTH)) begin
               held_in = held_ff + 1'b1;
            end
         end
      end
   end

   // peak window: written in finish for non-final peaks; scan reads are registered
   always_ff @(posedge clock) begin
      if (mem_write) begin
         window_mem[wslot_ff] <= '{bin: item_bin_ff, frame: item_frame_ff};
      end
      if (rd_issue) begin
         rd_ff <= window_mem[rslot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= lpg_pkg::STEP_IDLE;
         fan_ff        <= lpg_pkg::FAN_RESET;
         min_ff        <= lpg_pkg::MIN_DELTA_RESET;
         max_ff        <= lpg_pkg::MAX_DELTA_RESET;
         held_ff       <= '0;
         wslot_ff      <= '0;
         remain_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         fan_ff        <= fan_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         held_ff       <= held_in;
         wslot_ff      <= wslot_in;
         remain_ff     <= remain_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rslot_ff      <= rslot_in;
      item_bin_ff   <= item_bin_in;
      item_frame_ff <= item_frame_in;
      item_last_ff  <= item_last_in;
      pend_bin_ff   <= pend_bin_in;
      pend_delta_ff <= pend_delta_in;
      pend_frame_ff <= pend_frame_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* bench/landmark_pair_generator_test.sv */
// ----------------------------------------------------------------------------
// landmark_pair_generator_test
// Self-checking bench for the landmark pair generator. Peaks go in through a
// queue-fed driver, and each accepted peak is run through a local copy of the
// pairing window to build the list of expected pair beats. A monitor compares
// every result beat field by field with the oldest expected pair. Registers are
// rewritten between phases while the block is idle. Both sides idle at random in
// most phases, and one phase stalls the result side long enough to back up the input.
// ----------------------------------------------------------------------------
module landmark_pair_generator_test;

   localparam int DEPTH        = 14;
   localparam int DRAIN_CYCLES = 40;
   localparam int CHOKE_CYCLES = 400;
   localparam int MAX_REPORTS  = 10;

   // index past the last register, writes to it must be ignored
   localparam logic [lpg_pkg::IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [lpg_pkg::BIN_W-1:0]   bin;
      logic [lpg_pkg::FRAME_W-1:0] frame;
      logic                        fin;
   } peak_beat_type;

   typedef struct packed {
      logic [lpg_pkg::BIN_W-1:0]   anchor_bin;
      logic [lpg_pkg::BIN_W-1:0]   target_bin;
      logic [lpg_pkg::FRAME_W-1:0] delta;
      logic [lpg_pkg::FRAME_W-1:0] anchor_frame;
      logic                        run_end;
   } pair_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   peak_beat_type peak_queue[$];
   pair_beat_type pair_queue[$];
   peak_beat_type cur_peak;

   // local copy of the pairing window and register values
   logic [lpg_pkg::BIN_W-1:0]   held_bins [DEPTH];
   logic [lpg_pkg::FRAME_W-1:0] held_frames [DEPTH];
   int                          held_count = 0;
   int                          next_slot = 0;
   logic [lpg_pkg::FAN_W-1:0]   cfg_fan = lpg_pkg::FAN_RESET;
   logic [lpg_pkg::FRAME_W-1:0] cfg_min = lpg_pkg::MIN_DELTA_RESET;
   logic [lpg_pkg::FRAME_W-1:0] cfg_max = lpg_pkg::MAX_DELTA_RESET;

   int                          error_count = 0;
   bit                          idle_on = 1'b1;
   int                          send_gap = 0;
   int                          recv_gap = 0;
   logic                        send_valid;
   bit                          choke_go = 1'b0;
   bit                          choke_seen = 1'b0;
   int                          choke_left = 0;
   logic [lpg_pkg::FRAME_W-1:0] frame_now = '0;

   landmark_pair_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 30);
      end
   endfunction

   // pair the peak with the held window, oldest anchor first, then store it, or empty the window after a final peak
   task automatic predict_pairs(input peak_beat_type p);
      int                          fan;
      int                          n;
      int                          k;
      int                          slot;
      logic [lpg_pkg::FRAME_W-1:0] delta;
      pair_beat_type               pb;
      pair_beat_type               found[$];
      fan = (cfg_fan > DEPTH) ? DEPTH : int'(cfg_fan);
      n = (fan < held_count) ? fan : held_count;
      for (k = held_count - n; k < held_count; k++) begin
         slot = (next_slot + 2 * DEPTH - held_count + k) % DEPTH;
         // a frame going backwards never pairs
         if (p.frame >= held_frames[slot]) begin
            delta = p.frame - held_frames[slot];
            if (delta >= cfg_min && delta <= cfg_max) begin
               pb.anchor_bin   = held_bins[slot];
               pb.target_bin   = p.bin;
               pb.delta        = delta;
               pb.anchor_frame = held_frames[slot];
               pb.run_end      = 1'b0;
               found = {found, pb};
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].run_end = 1'b1;
      pair_queue = {pair_queue, found};
      if (p.fin) begin
         held_count = 0;
         next_slot = 0;
      end else begin
         held_bins[next_slot] = p.bin;
         held_frames[next_slot] = p.frame;
         next_slot = (next_slot + 1) % DEPTH;
         if (held_count < DEPTH) held_count++;
      end
   endtask

   task automatic check_pair(input logic [55:0] data, input logic last);
      pair_beat_type got;
      pair_beat_type want;
      got.anchor_bin   = data[11:0];
      got.target_bin   = data[23:12];
      got.delta        = data[39:24];
      got.anchor_frame = data[55:40];
      got.run_end      = last;
      if (pair_queue.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected pair beat: data %h last %b", data, last);
      end else begin
         want = pair_queue.pop_front();
         if (got != want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("pair mismatch: expected %0d %0d %0d %0d %b, got %0d %0d %0d %0d %b",
                        want.anchor_bin, want.target_bin, want.delta, want.anchor_frame,
                        want.run_end, got.anchor_bin, got.target_bin, got.delta,
                        got.anchor_frame, got.run_end);
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         send_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_pairs(cur_peak);
            send_valid = 1'b0;
            send_gap = pick_gap();
         end else if (!req_tvalid && send_gap > 0) begin
            send_gap--;
         end
         if (!send_valid && send_gap == 0 && peak_queue.size() > 0) begin
            cur_peak = peak_queue.pop_front();
            req_tdata <= {4'b0, cur_peak.frame, cur_peak.bin};
            req_tlast <= cur_peak.fin;
            send_valid = 1'b1;
         end
         req_tvalid <= send_valid;
      end
   end

   // long hold-off of the result side, counted here
   always @(posedge clock) begin
      if (reset) begin
         choke_left <= 0;
         choke_seen <= 1'b0;
      end else if (choke_go != choke_seen) begin
         choke_left <= CHOKE_CYCLES;
         choke_seen <= choke_go;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_pair(rsp_tdata, rsp_tlast);
            recv_gap = pick_gap();
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_tready <= (choke_left == 0) && (recv_gap == 0);
      end
   end

   task automatic write_csr(input logic [lpg_pkg::IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lpg_pkg::CSR_PAIR_FAN:  cfg_fan = value[lpg_pkg::FAN_W-1:0];
         lpg_pkg::CSR_MIN_DELTA: cfg_min = value;
         lpg_pkg::CSR_MAX_DELTA: cfg_max = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] fan_word, input logic [15:0] min_v,
                               input logic [15:0] max_v);
      write_csr(lpg_pkg::CSR_PAIR_FAN, fan_word);
      write_csr(lpg_pkg::CSR_MIN_DELTA, min_v);
      write_csr(lpg_pkg::CSR_MAX_DELTA, max_v);
   endtask

   task automatic wait_drained();
      while (peak_queue.size() != 0 || req_tvalid || pair_queue.size() != 0)
         @(posedge clock);
      // a peak with no pairs may still be finishing
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_peak(input logic [lpg_pkg::BIN_W-1:0] bin,
                           input logic [lpg_pkg::FRAME_W-1:0] frame, input logic fin);
      peak_beat_type p;
      p.bin = bin;
      p.frame = frame;
      p.fin = fin;
      peak_queue = {peak_queue, p};
   endtask

   function automatic logic [lpg_pkg::BIN_W-1:0] pick_bin();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return '0;
      end else if (r < 16) begin
         return 12'd2048;
      end else if (r < 22) begin
         return 12'hFFF;
      end else if (r < 30) begin
         return 12'($urandom_range(0, 4095));
      end else begin
         return 12'($urandom_range(0, 2048));
      end
   endfunction

   // one track of peaks whose frames mostly hold or rise, mostly closed by a final peak
   task automatic add_track(input int len, input int step_max);
      int r;
      int i;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         frame_now = 16'hFFFF - 16'($urandom_range(0, 40));
      end else if (r < 20) begin
         frame_now = 16'($urandom_range(0, 65535));
      end
      for (i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            frame_now = frame_now;
         end else if (r < 80) begin
            frame_now = frame_now + 16'($urandom_range(1, step_max));
         end else if (r < 94) begin
            frame_now = frame_now + 16'($urandom_range(step_max, 4 * step_max));
         end else if (r < 97) begin
            frame_now = frame_now + 16'($urandom_range(150, 300));
         end else begin
            frame_now = frame_now - 16'($urandom_range(1, 20));
         end
         add_peak(pick_bin(), frame_now,
                  (i == len - 1) && ($urandom_range(0, 99) < 85));
      end
   endtask

   task automatic add_items(input int total, input int step_max);
      int left;
      int len;
      left = total;
      while (left > 0) begin
         len = $urandom_range(1, 20);
         if (len > left) len = left;
         add_track(len, step_max);
         left -= len;
      end
   endtask

   initial begin
      int phase;
      int lo;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: edges of the delta range, bin extremes, ring wrap
      add_peak(12'd0, 16'd0, 1'b0);
      add_peak(12'hFFF, 16'd0, 1'b0);
      add_peak(12'd2048, 16'd1, 1'b0);
      add_peak(12'h555, 16'd100, 1'b0);
      add_peak(12'hAAA, 16'd200, 1'b0);
      add_peak(12'd7, 16'd201, 1'b0);
      add_peak(12'd9, 16'd150, 1'b0);
      add_peak(12'd1, 16'd201, 1'b1);
      for (int i = 0; i < 15; i++) add_peak(12'(i * 273), 16'd300, i == 14);
      add_peak(12'd3, 16'hFFFF, 1'b0);
      add_peak(12'd4, 16'hFFFF, 1'b1);
      wait_drained();

      for (phase = 0; phase < 12; phase++) begin
         idle_on = (phase != 5) && (phase != 9);
         case (phase)
            0: write_config(16'hFFFF, 16'd0, 16'hFFFF);
            1: write_config(16'hFFF0, 16'd0, 16'd200);
            2: write_config(16'd1, 16'd0, 16'd0);
            3: begin
               write_csr(CSR_UNUSED, 16'($urandom_range(0, 65535)));
               write_config(16'($urandom_range(0, 4095) << 4) | 16'd7,
                            16'd3, 16'd20);
            end
            4: write_config(16'd14, 16'd50, 16'd10);
            7: write_config(16'hFFFE, 16'hFFFF, 16'hFFFF);
            5, 6: write_config(16'd14, 16'd0, 16'hFFFF);
            default: begin
               lo = $urandom_range(0, 8);
               write_config(16'($urandom_range(0, 65535)), 16'(lo),
                            16'(lo + $urandom_range(0, 120)));
            end
         endcase
         if (phase == 5) begin
            // result side held off while peaks keep coming
            choke_go = ~choke_go;
            add_items(40, 1);
         end else if (phase == 6) begin
            add_items(15, 6);
            wait_drained();
            add_items(15, 6);
         end else if (phase == 7) begin
            add_peak(12'd5, 16'd0, 1'b0);
            add_peak(12'd6, 16'hFFFF, 1'b1);
            add_items(20, 10);
         end else begin
            add_items(20, (phase == 2 || phase == 3) ? 3 : 10);
         end
         wait_drained();
      end

      if (error_count == 0 && pair_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* landmark_pair_generator.f */
rtl/lpg_pkg.sv
rtl/landmark_pair_generator.sv
bench/landmark_pair_generator_test.sv
